### hw/rtl/gregorian_date_counter_top_macros.svh
// Assertion macros for the Gregorian date counter checker.
// Both expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef GREGORIAN_DATE_COUNTER_TOP_MACROS_SVH
`define GREGORIAN_DATE_COUNTER_TOP_MACROS_SVH

// Consequent must hold at the same clock edge as the antecedent.
`define GDC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold at the clock edge after the antecedent.
`define GDC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/gdc_pkg.sv
// Shared types, constants and calendar functions of the Gregorian date counter.
// No dependencies; imported by the step, weekday and top modules and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package gdc_pkg;

	// Operation selected by each input beat; code 7 behaves as a query.
	typedef enum logic [2:0] {
		MODE_LOAD       = 3'd0,
		MODE_NEXT_DAY   = 3'd1,
		MODE_PREV_DAY   = 3'd2,
		MODE_NEXT_MONTH = 3'd3,
		MODE_PREV_MONTH = 3'd4,
		MODE_ADD_YEARS  = 3'd5,
		MODE_QUERY      = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_LOAD = 2'd1,
		ST_RANGE    = 2'd2
	} status_t;

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
	} date_t;

	// Input beat after the entry checks.
	typedef struct packed {
		mode_t       mode;
		logic        load_ok;
		date_t       load_date;
		logic [14:0] year_delta;
	} item_t;

	// Load enables of the two weekday stages.
	typedef struct packed {
		logic s3;
		logic s4;
	} cal_en_t;

	// Everything the weekday stages hand to the output register.
	typedef struct packed {
		date_t      date;
		logic [2:0] weekday;
		logic       leap;
		logic       last;
	} cal_res_t;

	// Multiplicative inverses of 25 modulo 2^12 and 2^10, with the divisibility limits.
	localparam logic [11:0] INV25_12     = 12'd3113;
	localparam logic [11:0] DIV25_12_LIM = 12'd163;
	localparam logic [9:0]  INV25_10     = 10'd41;
	localparam logic [9:0]  DIV25_10_LIM = 10'd40;

	// Reciprocals: x / 100 = (x * RECIP100) >> 20 for x < 2^14,
	// x / 7 = (x * RECIP7) >> 18 for x < 2^15.
	localparam logic [14:0] RECIP100 = 15'd10486;
	localparam logic [15:0] RECIP7   = 16'd37450;

	// Leap test without a divider: divisibility by 25 via the modular inverse.
	function automatic logic is_leap(input logic [13:0] y);
		logic [23:0] p12;
		logic [19:0] p10;
		logic        d4;
		logic        d100;
		logic        d400;
		p12  = 24'(y[13:2]) * 24'(INV25_12);
		p10  = 20'(y[13:4]) * 20'(INV25_10);
		d4   = (y[1:0] == 2'b00);
		d100 = d4 && (p12[11:0] <= DIV25_12_LIM);
		d400 = (y[3:0] == 4'd0) && (p10[9:0] <= DIV25_10_LIM);
		return (d4 && !d100) || d400;
	endfunction

	// Month length; months outside 1..12 read as 31 and are rejected elsewhere.
	function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		unique case (m)
			4'd2:                   n = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
			default:                n = 5'd31;
		endcase
		return n;
	endfunction

	// (31 * mm) / 12 with mm the month counted from March (January and February last).
	function automatic logic [4:0] month_offset(input logic [3:0] m);
		logic [4:0] r;
		unique case (m)
			4'd1:    r = 5'd28;
			4'd2:    r = 5'd31;
			4'd3:    r = 5'd2;
			4'd4:    r = 5'd5;
			4'd5:    r = 5'd7;
			4'd6:    r = 5'd10;
			4'd7:    r = 5'd12;
			4'd8:    r = 5'd15;
			4'd9:    r = 5'd18;
			4'd10:   r = 5'd20;
			4'd11:   r = 5'd23;
			4'd12:   r = 5'd25;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/gdc_step.sv
// Date step stage: holds the current date and applies one operation per beat.
// Depends on gdc_pkg for the item and date types and the calendar functions.
`timescale 1ns / 1ps
`default_nettype none

module gdc_step
	import gdc_pkg::*;
#(
	parameter int unsigned YEAR_MAX = 9999
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    en,
	input  wire item_t   item,
	output date_t        date,
	output status_t      status
);

	localparam logic [13:0]        YMAX   = 14'(YEAR_MAX);
	localparam logic signed [15:0] YMAX_S = 16'(YEAR_MAX);

	date_t              cur_q;
	date_t              nxt;
	status_t            st;
	logic               lp;
	logic [4:0]         dim;
	logic [4:0]         nm_dim;
	logic [4:0]         pm_dim;
	logic signed [15:0] ny;
	logic [4:0]         ny_dim;

	// Next date from the held date and the selected operation.
	always_comb begin
		lp     = is_leap(cur_q.year);
		dim    = days_in(cur_q.month, lp);
		nm_dim = days_in(cur_q.month + 4'd1, lp);
		pm_dim = days_in(cur_q.month - 4'd1, lp);
		ny     = $signed({2'b00, cur_q.year}) + $signed({item.year_delta[14], item.year_delta});
		ny_dim = days_in(cur_q.month, is_leap(ny[13:0]));
		nxt    = cur_q;
		st     = ST_OK;
		unique case (item.mode)
			MODE_LOAD: begin
				if (item.load_ok) begin
					nxt = item.load_date;
				end else begin
					st = ST_BAD_LOAD;
				end
			end
			MODE_NEXT_DAY: begin
				if (cur_q.day < dim) begin
					nxt.day = cur_q.day + 5'd1;
				end else if (cur_q.month < MONTH_DEC) begin
					nxt.day   = 5'd1;
					nxt.month = cur_q.month + 4'd1;
				end else if (cur_q.year < YMAX) begin
					nxt.day   = 5'd1;
					nxt.month = MONTH_JAN;
					nxt.year  = cur_q.year + 14'd1;
				end else begin
					st = ST_RANGE;
				end
			end
			MODE_PREV_DAY: begin
				if (cur_q.day > 5'd1) begin
					nxt.day = cur_q.day - 5'd1;
				end else if (cur_q.month > MONTH_JAN) begin
					nxt.month = cur_q.month - 4'd1;
					nxt.day   = pm_dim;
				end else if (cur_q.year > 14'd1) begin
					nxt.year  = cur_q.year - 14'd1;
					nxt.month = MONTH_DEC;
					nxt.day   = 5'd31;
				end else begin
					st = ST_RANGE;
				end
			end
			MODE_NEXT_MONTH: begin
				// A step into January keeps the day, as January has 31 days.
				if (cur_q.month < MONTH_DEC) begin
					nxt.month = cur_q.month + 4'd1;
					nxt.day   = (cur_q.day > nm_dim) ? nm_dim : cur_q.day;
				end else if (cur_q.year < YMAX) begin
					nxt.month = MONTH_JAN;
					nxt.year  = cur_q.year + 14'd1;
				end else begin
					st = ST_RANGE;
				end
			end
			MODE_PREV_MONTH: begin
				// A step into December keeps the day, as December has 31 days.
				if (cur_q.month > MONTH_JAN) begin
					nxt.month = cur_q.month - 4'd1;
					nxt.day   = (cur_q.day > pm_dim) ? pm_dim : cur_q.day;
				end else if (cur_q.year > 14'd1) begin
					nxt.month = MONTH_DEC;
					nxt.year  = cur_q.year - 14'd1;
				end else begin
					st = ST_RANGE;
				end
			end
			MODE_ADD_YEARS: begin
				if (ny < 16'sd1 || ny > YMAX_S) begin
					st = ST_RANGE;
				end else begin
					nxt.year = ny[13:0];
					nxt.day  = (cur_q.day > ny_dim) ? ny_dim : cur_q.day;
				end
			end
			default: begin
			end
		endcase
	end

	assign date   = (st == ST_OK) ? nxt : cur_q;
	assign status = st;

	// Held date; a rejected step leaves it as it is.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q.day   <= 5'd1;
			cur_q.month <= MONTH_JAN;
			cur_q.year  <= 14'd2000;
		end else if (en) begin
			cur_q <= date;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/gdc_cal.sv
// Weekday and flag stages: leap year, last day of month and day of week.
// Depends on gdc_pkg; the day of week uses constant reciprocals, no divider.
`timescale 1ns / 1ps
`default_nettype none

module gdc_cal
	import gdc_pkg::*;
(
	input  wire logic    clk,
	input  wire cal_en_t en,
	input  wire date_t   date_in,
	output cal_res_t     res
);

	logic        jan_feb;
	logic [13:0] yy;
	logic [28:0] q100_full;
	logic        leap;

	date_t       date_s3;
	logic [13:0] yy_s3;
	logic [7:0]  q100_s3;
	logic [4:0]  moff_s3;
	logic        leap_s3;
	logic        last_s3;

	logic [14:0] sum;
	logic [30:0] q7_full;

	date_t       date_s4;
	logic [14:0] sum_s4;
	logic [12:0] q7_s4;
	logic        leap_s4;
	logic        last_s4;

	logic [14:0] wd_full;

	// First stage: shifted year, its hundreds and the month flags.
	always_comb begin
		jan_feb   = (date_in.month <= MONTH_FEB);
		yy        = date_in.year - 14'(jan_feb);
		q100_full = 29'(yy) * 29'(RECIP100);
		leap      = is_leap(date_in.year);
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			date_s3 <= date_in;
			yy_s3   <= yy;
			q100_s3 <= q100_full[27:20];
			moff_s3 <= month_offset(date_in.month);
			leap_s3 <= leap;
			last_s3 <= (date_in.day == days_in(date_in.month, leap));
		end
	end

	// Second stage: day count sum and its quotient by seven.
	always_comb begin
		sum = 15'(date_s3.day) + 15'(yy_s3) + 15'(yy_s3[13:2]) - 15'(q100_s3)
			+ 15'(q100_s3[7:2]) + 15'(moff_s3);
		q7_full = 31'(sum) * 31'(RECIP7);
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			date_s4 <= date_s3;
			sum_s4  <= sum;
			q7_s4   <= q7_full[30:18];
			leap_s4 <= leap_s3;
			last_s4 <= last_s3;
		end
	end

	// Remainder by seven gives the weekday, Sunday as zero.
	assign wd_full     = sum_s4 - (15'(q7_s4) << 3) + 15'(q7_s4);
	assign res.date    = date_s4;
	assign res.weekday = wd_full[2:0];
	assign res.leap    = leap_s4;
	assign res.last    = last_s4;

endmodule

`default_nettype wire

### hw/rtl/gregorian_date_counter_top.sv
// Gregorian date counter: an input beat is taken every cycle while the output
// can move; its result passes the input, step, two weekday and output registers.
// The held date is updated in the single step stage, so back-to-back beats see
// each other's dates with no gap; weekday is derived in two further stages.
// Reset (asynchronous, active low) gives 1 January 2000, a weekend mask of
// Friday and Saturday, and an empty pipeline.
`timescale 1ns / 1ps
`default_nettype none

module gregorian_date_counter_top
	import gdc_pkg::*;
#(
	parameter int unsigned YEAR_MAX = 9999
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	// Input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // load_day, load_month, load_year, year_delta
	input  wire logic [2:0]  s_tuser,  // mode
	// Result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // day, month, year, weekday, leap_year,
	                                   // last_of_month, weekend
	output logic [1:0]       m_tuser   // status
);

	localparam logic [13:0] YMAX = 14'(YEAR_MAX);

	logic [6:0]  weekend_mask_q;

	item_t       in_item;
	logic        ld_leap;

	logic        v_s1;
	logic        v_s2;
	logic        v_s3;
	logic        v_s4;
	logic        adv1;
	logic        adv2;
	logic        adv3;
	logic        adv4;

	item_t       item_s1;
	date_t       step_date;
	status_t     step_status;
	date_t       date_s2;
	status_t     status_s2;
	status_t     status_s3;
	status_t     status_s4;
	cal_en_t     cal_en;
	cal_res_t    cal_res;
	logic [7:0]  mask_ext;

	logic        out_valid_q;
	cal_res_t    out_res_q;
	logic        out_weekend_q;
	status_t     out_status_q;

	// Configuration register; it answers at addresses 0 to 3, and 4 to 7 read as zero.
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {25'd0, weekend_mask_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weekend_mask_q <= 7'd96;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			weekend_mask_q <= pwdata[6:0];
		end
	end

	// Unpack the input beat and check a load date before it enters.
	always_comb begin
		in_item.mode                 = mode_t'(s_tuser);
		in_item.load_date.day        = s_tdata[4:0];
		in_item.load_date.month      = s_tdata[8:5];
		in_item.load_date.year       = s_tdata[22:9];
		in_item.year_delta           = s_tdata[37:23];
		ld_leap                      = is_leap(in_item.load_date.year);
		in_item.load_ok = (in_item.load_date.month >= MONTH_JAN)
			&& (in_item.load_date.month <= MONTH_DEC)
			&& (in_item.load_date.year != 14'd0)
			&& (in_item.load_date.year <= YMAX)
			&& (in_item.load_date.day != 5'd0)
			&& (in_item.load_date.day <= days_in(in_item.load_date.month, ld_leap));
	end

	// Each stage moves on when the next one is empty or moving too.
	assign adv4     = v_s4 && (!out_valid_q || m_tready);
	assign adv3     = v_s3 && (!v_s4 || adv4);
	assign adv2     = v_s2 && (!v_s3 || adv3);
	assign adv1     = v_s1 && (!v_s2 || adv2);
	assign s_tready = !v_s1 || adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				v_s1 <= 1'b1;
			end else if (adv1) begin
				v_s1 <= 1'b0;
			end
			if (adv1) begin
				v_s2 <= 1'b1;
			end else if (adv2) begin
				v_s2 <= 1'b0;
			end
			if (adv2) begin
				v_s3 <= 1'b1;
			end else if (adv3) begin
				v_s3 <= 1'b0;
			end
			if (adv3) begin
				v_s4 <= 1'b1;
			end else if (adv4) begin
				v_s4 <= 1'b0;
			end
			if (adv4) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= in_item;
		end
	end

	// Date step and the held date.
	gdc_step #(
		.YEAR_MAX (YEAR_MAX)
	) u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv1),
		.item   (item_s1),
		.date   (step_date),
		.status (step_status)
	);

	// Step result register and the status that travels alongside the weekday stages.
	always_ff @(posedge clk) begin
		if (adv1) begin
			date_s2   <= step_date;
			status_s2 <= step_status;
		end
		if (adv2) begin
			status_s3 <= status_s2;
		end
		if (adv3) begin
			status_s4 <= status_s3;
		end
	end

	assign cal_en.s3 = adv2;
	assign cal_en.s4 = adv3;

	gdc_cal u_cal (
		.clk     (clk),
		.en      (cal_en),
		.date_in (date_s2),
		.res     (cal_res)
	);

	// Output register with the weekend lookup.
	assign mask_ext = {1'b0, weekend_mask_q};

	always_ff @(posedge clk) begin
		if (adv4) begin
			out_res_q     <= cal_res;
			out_weekend_q <= mask_ext[cal_res.weekday];
			out_status_q  <= status_s4;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'd0, out_weekend_q, out_res_q.last, out_res_q.leap,
		out_res_q.weekday, out_res_q.date.year, out_res_q.date.month, out_res_q.date.day};
	assign m_tuser  = out_status_q;

endmodule

`default_nettype wire

### hw/rtl/gdc_checker.sv
// Port-level checks on the result stream of the Gregorian date counter.
// Uses the assertion macros header; bound to the top level below.
`timescale 1ns / 1ps
`default_nettype none
`include "gregorian_date_counter_top_macros.svh"

module gdc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [1:0]  m_tuser
);

	logic [4:0]  day;
	logic [3:0]  month;
	logic [13:0] year;
	logic [2:0]  weekday;
	logic        leap;
	logic        last;

	assign day     = m_tdata[4:0];
	assign month   = m_tdata[8:5];
	assign year    = m_tdata[22:9];
	assign weekday = m_tdata[25:23];
	assign leap    = m_tdata[26];
	assign last    = m_tdata[27];

	// A stalled result beat is held unchanged.
	`GDC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

	// Every reported date has a nonzero day and year and a month from 1 to 12.
	`GDC_ASSERT_SAME(a_date_valid, m_tvalid, day != 5'd0 && month != 4'd0 && month <= 4'd12 && year != 14'd0, "reported date out of range")

	// The end of February agrees with the leap flag.
	`GDC_ASSERT_SAME(a_feb_end, m_tvalid && month == 4'd2 && last, day == (leap ? 5'd29 : 5'd28), "end of February disagrees with leap flag")

	// Leap years are multiples of four.
	`GDC_ASSERT_SAME(a_leap_div4, m_tvalid && leap, year[1:0] == 2'b00, "leap flag on a year not divisible by four")

	// The weekday is a remainder by seven.
	`GDC_ASSERT_SAME(a_weekday_range, m_tvalid, weekday != 3'd7, "weekday out of range")

endmodule

bind gregorian_date_counter_top gdc_checker u_gdc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

### tb/gregorian_date_counter_top_test.sv
// Self-checking testbench for gregorian_date_counter_top: random and directed date
// operations on the input stream, results checked against a calendar scoreboard.
// Depends on gdc_pkg and the gregorian_date_counter_top RTL only.
`timescale 1ns / 1ps

module gregorian_date_counter_top_test;
	import gdc_pkg::*;

	localparam int          YEAR_LIMIT   = 9999;
	localparam logic [2:0]  MODE_SPARE   = 3'd7;
	localparam logic [2:0]  ADDR_WEEKEND = 3'd0;
	localparam logic [2:0]  ADDR_UNUSED  = 3'd4;
	localparam int          HOLD_CYCLES  = 200;
	localparam int          DRAIN_CYCLES = 20;
	localparam int          PHASES       = 5;
	localparam int          PHASE_BEATS  = 100;

	// One predicted result beat.
	typedef struct {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic [2:0]  wday;
		logic        leap;
		logic        last;
		logic        wkend;
		status_t     st;
	} day_result_t;

	// Calendar scoreboard: tracks the held date and the weekend mask, and keeps
	// the results still owed by the block in order of acceptance.
	class date_scoreboard;
		int          cur_d;
		int          cur_m;
		int          cur_y;
		logic [6:0]  mask;
		day_result_t owed_q[$];
		int          errors;

		function new();
			cur_d  = 1;
			cur_m  = 1;
			cur_y  = 2000;
			mask   = 7'd96;
			errors = 0;
		endfunction

		static function bit leap_of(int y);
			return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		endfunction

		static function int month_len(int m, int y);
			case (m)
				2:              return leap_of(y) ? 29 : 28;
				4, 6, 9, 11:    return 30;
				default:        return 31;
			endcase
		endfunction

		// Day of week with March as the first month of the shifted year.
		static function int weekday_of(int d, int m, int y);
			int shift;
			int yy;
			int mm;
			shift = (14 - m) / 12;
			yy    = y - shift;
			mm    = m + 12 * shift - 2;
			return (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		// Applies one accepted input beat to the held date and queues its result.
		function void note_input(logic [2:0] mode, logic [4:0] ld, logic [3:0] lm,
				logic [13:0] ly, logic [14:0] delta);
			int          d;
			int          m;
			int          y;
			int          ny;
			int          wd;
			status_t     st;
			day_result_t r;
			d  = cur_d;
			m  = cur_m;
			y  = cur_y;
			st = ST_OK;
			case (mode)
				MODE_LOAD: begin
					if (lm >= 1 && lm <= 12 && ly >= 1 && ly <= YEAR_LIMIT &&
							ld >= 1 && ld <= month_len(lm, ly)) begin
						d = ld;
						m = lm;
						y = ly;
					end else begin
						st = ST_BAD_LOAD;
					end
				end
				MODE_NEXT_DAY: begin
					if (d < month_len(m, y)) begin
						d++;
					end else if (m < 12) begin
						d = 1;
						m++;
					end else if (y < YEAR_LIMIT) begin
						d = 1;
						m = 1;
						y++;
					end else begin
						st = ST_RANGE;
					end
				end
				MODE_PREV_DAY: begin
					if (d > 1) begin
						d--;
					end else if (m > 1) begin
						m--;
						d = month_len(m, y);
					end else if (y > 1) begin
						y--;
						m = 12;
						d = 31;
					end else begin
						st = ST_RANGE;
					end
				end
				MODE_NEXT_MONTH: begin
					if (m < 12) begin
						m++;
					end else if (y < YEAR_LIMIT) begin
						m = 1;
						y++;
					end else begin
						st = ST_RANGE;
					end
					if (d > month_len(m, y))
						d = month_len(m, y);
				end
				MODE_PREV_MONTH: begin
					if (m > 1) begin
						m--;
					end else if (y > 1) begin
						m = 12;
						y--;
					end else begin
						st = ST_RANGE;
					end
					if (d > month_len(m, y))
						d = month_len(m, y);
				end
				MODE_ADD_YEARS: begin
					ny = y + int'($signed(delta));
					if (ny < 1 || ny > YEAR_LIMIT) begin
						st = ST_RANGE;
					end else begin
						y = ny;
						if (d > month_len(m, y))
							d = month_len(m, y);
					end
				end
				default: ;
			endcase
			if (st == ST_OK) begin
				cur_d = d;
				cur_m = m;
				cur_y = y;
			end
			wd      = weekday_of(cur_d, cur_m, cur_y);
			r.day   = 5'(cur_d);
			r.month = 4'(cur_m);
			r.year  = 14'(cur_y);
			r.wday  = 3'(wd);
			r.leap  = leap_of(cur_y);
			r.last  = (cur_d == month_len(cur_m, cur_y));
			r.wkend = mask[wd];
			r.st    = st;
			owed_q.push_back(r);
		endfunction

		task report(string what, int got, int want);
			$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
			errors++;
		endtask

		// Compares one accepted result beat with the oldest owed result.
		task check(logic [31:0] data, logic [1:0] user);
			day_result_t r;
			if (owed_q.size() == 0) begin
				report("result beat with nothing owed", data, 0);
			end else begin
				r = owed_q.pop_front();
				if (data[4:0] != r.day)     report("day", data[4:0], r.day);
				if (data[8:5] != r.month)   report("month", data[8:5], r.month);
				if (data[22:9] != r.year)   report("year", data[22:9], r.year);
				if (data[25:23] != r.wday)  report("weekday", data[25:23], r.wday);
				if (data[26] != r.leap)     report("leap_year", data[26], r.leap);
				if (data[27] != r.last)     report("last_of_month", data[27], r.last);
				if (data[28] != r.wkend)    report("weekend", data[28], r.wkend);
				if (data[31:29] != 3'd0)    report("tdata padding", data[31:29], 0);
				if (user != r.st)           report("status", user, r.st);
			end
		endtask
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;  // load_day, load_month, load_year, year_delta
	logic [2:0]  s_tuser  = '0;  // mode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // day, month, year, weekday, leap_year,
	                             // last_of_month, weekend
	logic [1:0]  m_tuser;        // status

	bit             idle_on  = 1'b0;
	bit             hold_req = 1'b0;
	date_scoreboard sb       = new();

	gregorian_date_counter_top #(
		.YEAR_MAX(YEAR_LIMIT)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #2 clk = ~clk;

	// Observe both streams at every edge; input beats are noted before results.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_input(s_tuser, s_tdata[4:0], s_tdata[8:5], s_tdata[22:9],
					s_tdata[37:23]);
			if (m_tvalid && m_tready)
				sb.check(m_tdata, m_tuser);
		end
	end

	// Result side: random ready and stall bursts, plus a long hold-off on request.
	initial begin
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	// Offers one input beat and waits until it is taken; may leave a gap after it.
	task automatic send_beat(input logic [2:0] mode, input int ld, input int lm,
			input int ly, input int dl);
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {2'b00, 15'(dl), 14'(ly), 4'(lm), 5'(ld)};
		do @(posedge clk); while (!s_tready);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// Drops the input stream and waits until every owed result has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_WEEKEND)
			sb.mask = value[6:0];
		@(posedge clk);
	endtask

	// Valid load biased towards the ends of the year range, centuries and month ends.
	task automatic send_valid_load();
		int y;
		int m;
		int d;
		case ($urandom_range(0, 3))
			0:       y = $urandom_range(1, 3);
			1:       y = $urandom_range(YEAR_LIMIT - 2, YEAR_LIMIT);
			2:       y = 100 * $urandom_range(15, 25) + $urandom_range(0, 4) - 2;
			default: y = $urandom_range(1, YEAR_LIMIT);
		endcase
		m = $urandom_range(1, 12);
		if ($urandom_range(0, 1) == 0)
			d = date_scoreboard::month_len(m, y);
		else
			d = $urandom_range(1, date_scoreboard::month_len(m, y));
		send_beat(MODE_LOAD, d, m, y, $urandom_range(0, 32767));
	endtask

	// One random operation; loads are often followed by a run of day steps.
	task automatic send_random_op();
		int sel;
		int dl;
		sel = $urandom_range(0, 99);
		dl  = $urandom_range(0, 32767);
		if (sel < 12) begin
			send_valid_load();
			repeat ($urandom_range(0, 4))
				send_beat($urandom_range(0, 1) ? MODE_NEXT_DAY : MODE_PREV_DAY,
					$urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 16383), dl);
		end else if (sel < 17) begin
			send_beat(MODE_LOAD, $urandom_range(0, 31), $urandom_range(0, 15),
				$urandom_range(0, 16383), dl);
		end else if (sel < 40) begin
			send_beat(MODE_NEXT_DAY, $urandom_range(0, 31), $urandom_range(0, 15),
				$urandom_range(0, 16383), dl);
		end else if (sel < 55) begin
			send_beat(MODE_PREV_DAY, $urandom_range(0, 31), $urandom_range(0, 15),
				$urandom_range(0, 16383), dl);
		end else if (sel < 67) begin
			send_beat(MODE_NEXT_MONTH, $urandom_range(0, 31), $urandom_range(0, 15),
				$urandom_range(0, 16383), dl);
		end else if (sel < 78) begin
			send_beat(MODE_PREV_MONTH, $urandom_range(0, 31), $urandom_range(0, 15),
				$urandom_range(0, 16383), dl);
		end else if (sel < 91) begin
			// Small deltas exercise leap-day clamping, large ones the range limits.
			if ($urandom_range(0, 2) == 0)
				dl = int'($urandom_range(0, 2 * YEAR_LIMIT)) - YEAR_LIMIT;
			else
				dl = int'($urandom_range(0, 8)) - 4;
			send_beat(MODE_ADD_YEARS, $urandom_range(0, 31), $urandom_range(0, 15),
				$urandom_range(0, 16383), dl);
		end else if (sel < 96) begin
			send_beat(MODE_QUERY, $urandom_range(0, 31), $urandom_range(0, 15),
				$urandom_range(0, 16383), dl);
		end else begin
			send_beat(MODE_SPARE, $urandom_range(0, 31), $urandom_range(0, 15),
				$urandom_range(0, 16383), dl);
		end
	endtask

	// Main stimulus.
	initial begin
		logic [31:0] mask_val;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset date, leap-day clamping, invalid loads and both range ends.
		send_beat(MODE_QUERY, 0, 0, 0, 0);
		send_beat(MODE_PREV_DAY, 0, 0, 0, 0);
		send_beat(MODE_LOAD, 29, 2, 2000, 0);
		send_beat(MODE_ADD_YEARS, 0, 0, 0, 1);
		send_beat(MODE_ADD_YEARS, 0, 0, 0, 0);
		send_beat(MODE_LOAD, 29, 2, 1900, 0);
		send_beat(MODE_LOAD, 31, 4, 2023, 0);
		send_beat(MODE_LOAD, 0, 1, 2000, 0);
		send_beat(MODE_LOAD, 1, 13, 2000, 0);
		send_beat(MODE_LOAD, 31, 15, 16383, 32767);
		send_beat(MODE_LOAD, 1, 1, 0, 0);
		send_beat(MODE_LOAD, 31, 12, YEAR_LIMIT, 0);
		send_beat(MODE_NEXT_DAY, 0, 0, 0, 0);
		send_beat(MODE_NEXT_MONTH, 0, 0, 0, 0);
		send_beat(MODE_ADD_YEARS, 0, 0, 0, 1);
		send_beat(MODE_ADD_YEARS, 0, 0, 0, -(YEAR_LIMIT - 1));
		send_beat(MODE_LOAD, 1, 1, 1, 0);
		send_beat(MODE_PREV_DAY, 0, 0, 0, 0);
		send_beat(MODE_PREV_MONTH, 0, 0, 0, 0);
		send_beat(MODE_ADD_YEARS, 0, 0, 0, -1);
		send_beat(MODE_ADD_YEARS, 0, 0, 0, YEAR_LIMIT);
		send_beat(MODE_ADD_YEARS, 0, 0, 0, YEAR_LIMIT - 1);
		send_beat(MODE_LOAD, 31, 1, 2024, 0);
		send_beat(MODE_NEXT_MONTH, 0, 0, 0, 0);
		send_beat(MODE_SPARE, 31, 15, 16383, -YEAR_LIMIT);

		// Random phases, each under its own weekend mask; the last one runs flat out.
		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			repeat (DRAIN_CYCLES) @(posedge clk);
			case (p)
				0:       mask_val = 32'd0;
				1:       mask_val = 32'd127;
				4:       mask_val = 32'd96;
				default: mask_val = 32'($urandom_range(0, 127));
			endcase
			write_reg(ADDR_WEEKEND, mask_val);
			if (p == 1)
				write_reg(ADDR_UNUSED, 32'h0000_0011);
			idle_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
			for (int i = 0; i < PHASE_BEATS; i++) begin
				if (p == 1 && i == 40)
					hold_req = 1'b1;
				if (p == 3 && i == 60)
					drain_results();
				send_random_op();
			end
		end

		// Let the pipeline empty, then allow for stray beats.
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog.
	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
